### design/pkes_pkg.sv
// Package for the paced key edge scheduler: payload words, status codes,
// function codes and key helpers. No dependencies.
`default_nettype none
package pkes_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] key_code;
        logic        key_value;
        logic        matrix_modifier;
        logic [7:0]  request_tag;
    } t_in_word;

    typedef struct packed {
        logic [23:0] out_key_code;
        logic        out_value;
        logic [7:0]  out_tag;
        logic [2:0]  status;
        logic [5:0]  modifier_mask;
        logic        last;
    } t_out_word;

    // queued edge: modifier flag, tag, value, key code
    typedef struct packed {
        logic        mflag;
        logic [7:0]  tag;
        logic        val;
        logic [23:0] kc;
    } t_edge;

    localparam logic [1:0] FUNC_EDGE  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [2:0] ST_APPLIED   = 3'd0;
    localparam logic [2:0] ST_COALESCED = 3'd1;
    localparam logic [2:0] ST_NO_SLOT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_CLEAR     = 3'd4;

    localparam logic [31:0] FAR_PAST  = 32'hFFFE_7960;
    localparam int          MAX_OUT   = 32;
    localparam logic [6:0]  DOWN_MAX  = 7'd127;

    localparam logic [1:0] REG_HOLD = 2'd0;
    localparam logic [1:0] REG_GAP  = 2'd1;
    localparam logic [1:0] REG_EXCL = 2'd2;

    function automatic logic [23:0] key_id(input logic [23:0] kc);
        key_id = kc[23] ? (kc & 24'h80FFFF) : (kc & 24'h7FFFFF);
    endfunction

    function automatic logic [5:0] host_mod_bit(input logic [23:0] kc);
        logic [5:0] b;
        b = 6'd0;
        if (!kc[23]) begin
            case (kc[22:0])
                23'hffe1: b = 6'h01;
                23'hffe2: b = 6'h02;
                23'hffe3: b = 6'h04;
                23'hffe4: b = 6'h08;
                23'hffe9: b = 6'h10;
                23'hffea: b = 6'h20;
                23'hfe03: b = 6'h20;
                default:  b = 6'd0;
            endcase
        end
        host_mod_bit = b;
    endfunction

    // true when now < base + add, base signed 32, add unsigned 8
    function automatic logic gate_wait(input logic [31:0] now, input logic [31:0] base,
                                       input logic [7:0] add);
        logic signed [33:0] g;
        logic signed [33:0] n;
        g = {{2{base[31]}}, base} + {26'd0, add};
        n = {{2{now[31]}}, now};
        gate_wait = n < g;
    endfunction

    // controller commands
    typedef struct packed {
        logic load_item;    // capture input item
        logic find_start;   // reset search pointer
        logic find_step;    // examine one slot
        logic edge_finish;  // answer or enqueue the edge
        logic do_clear;     // free slots, answer the clear
        logic clear_step;
        logic tick_start;   // advance frame, set up walk
        logic walk_load;    // read next queue entry
        logic walk_eval;    // blocked list/search done: decide
        logic blk_step;
        logic walk_done;    // commit kept entries
        logic copy_step;
    } t_cmd;

    typedef struct packed {
        logic find_done;
        logic walk_more;    // another entry to read
        logic blk_done;
        logic copy_done;
        logic is_tick;
        logic is_edge;
        logic is_clear;
    } t_sts;

endpackage
`default_nettype wire

### design/pkes_datapath.sv
// Datapath of the paced key edge scheduler: slot table, pending queue,
// frame counters and result register. Depends on pkes_pkg.
`default_nettype none
module pkes_datapath
    import pkes_pkg::*;
#(
    parameter int SLOT_COUNT  = 64,
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_word  i_item,
    input  wire logic [7:0] i_hold,
    input  wire logic [7:0] i_gap,
    input  wire logic      i_excl,
    input  wire t_cmd      i_cmd,
    output t_sts           o_sts,
    output logic           o_valid,
    output t_out_word      o_word
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SCW = $clog2(SLOT_COUNT + 1);

    // slot table: used, wanted and applied bits in flops, keys and frame stamps in memory
    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] r_wanted;
    logic [SLOT_COUNT-1:0] r_applied;
    logic [23:0] m_key [SLOT_COUNT];
    logic [31:0] m_press [SLOT_COUNT];
    logic [31:0] m_rel [SLOT_COUNT];
    t_edge       m_q [QUEUE_DEPTH];
    t_edge       m_keep [QUEUE_DEPTH];
    logic [23:0] m_blk [QUEUE_DEPTH];

    t_in_word    r_item;
    logic [31:0] r_frame, r_last_rel;
    logic [CW-1:0] r_pcount;
    logic [6:0]  r_down;
    logic [5:0]  r_mods;

    logic [SCW-1:0] r_sidx;
    logic [23:0] r_key_rd;
    logic        r_hit, r_free_ok;
    logic [SW-1:0] r_hit_idx, r_free_idx;
    logic [23:0] r_id;

    logic [CW-1:0] r_qi, r_nk, r_nb, r_bi, r_ci;
    logic [5:0]  r_nout;
    logic        r_stop;
    t_edge       r_e;
    logic [23:0] r_blk_rd;
    logic        r_is_blk;
    logic [31:0] r_press_rd, r_rel_rd;
    logic        r_walk_active;

    // walk result held back one decision so the final one can carry last
    t_out_word   r_hw;
    logic        r_hv;

    logic        n_find_done;
    assign n_find_done = (r_sidx == SCW'(SLOT_COUNT));

    // examine one slot per cycle; key read is registered, so each compare comes in the cycle after its index
    logic        r_cmp_v;
    logic [SW-1:0] r_cmp_idx;

    always_ff @(posedge i_clk) begin
        r_key_rd   <= m_key[r_sidx[SW-1:0]];
        r_blk_rd   <= m_blk[r_bi[QW-1:0]];
        r_press_rd <= m_press[r_hit_idx];
        r_rel_rd   <= m_rel[r_hit_idx];
    end

    t_edge q_rd;
    always_ff @(posedge i_clk) q_rd <= m_q[r_qi[QW-1:0]];

    logic [SW-1:0] slot_s;
    assign slot_s = r_hit ? r_hit_idx : r_free_idx;
    logic slot_ok;
    assign slot_ok = r_hit || r_free_ok;

    // walk decision signals
    logic w_val, w_mod, w_gwait, w_xwait;
    logic [5:0] w_b;
    logic [31:0] w_pf, w_rf;
    always_comb begin
        w_val = r_e.val;
        w_b = host_mod_bit(r_e.kc);
        w_mod = (w_b != 6'd0) || r_e.mflag;
        // new slot reads as far past
        w_pf = r_hit ? r_press_rd : FAR_PAST;
        w_rf = r_hit ? r_rel_rd : FAR_PAST;
        w_gwait = w_val ? gate_wait(r_frame, w_rf, i_gap) : gate_wait(r_frame, w_pf, i_hold);
        w_xwait = i_excl && w_val && !w_mod &&
                  ((r_down != 7'd0) || gate_wait(r_frame, r_last_rel, i_gap));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0; r_frame <= '0; r_last_rel <= FAR_PAST; r_pcount <= '0;
            r_down <= '0; r_mods <= '0; o_valid <= 1'b0; r_cmp_v <= 1'b0;
            r_walk_active <= 1'b0; r_hv <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_cmp_v <= 1'b0;
            if (i_cmd.load_item) r_item <= i_item;
            if (i_cmd.find_start) begin
                r_sidx <= '0; r_hit <= 1'b0; r_free_ok <= 1'b0;
                r_id <= r_walk_active ? key_id(r_e.kc) : key_id(r_item.key_code);
            end
            if (i_cmd.find_step) begin
                if (!n_find_done) begin
                    r_sidx <= r_sidx + 1'b1;
                    r_cmp_v <= 1'b1;
                    r_cmp_idx <= r_sidx[SW-1:0];
                end
            end
            if (r_cmp_v && !r_hit) begin
                if (r_used[r_cmp_idx] && r_key_rd == r_id) begin
                    r_hit <= 1'b1; r_hit_idx <= r_cmp_idx;
                end else if (!r_used[r_cmp_idx] && !r_free_ok) begin
                    r_free_ok <= 1'b1; r_free_idx <= r_cmp_idx;
                end
            end
            if (i_cmd.edge_finish) begin
                o_valid <= 1'b1;
                o_word.out_key_code <= r_item.key_code;
                o_word.out_value <= r_item.key_value;
                o_word.out_tag <= r_item.request_tag;
                o_word.modifier_mask <= r_mods;
                o_word.last <= 1'b1;
                if (slot_ok && !r_hit) begin
                    r_used[r_free_idx] <= 1'b1;
                    m_key[r_free_idx] <= r_id;
                    r_wanted[r_free_idx] <= 1'b0;
                    r_applied[r_free_idx] <= 1'b0;
                    m_press[r_free_idx] <= FAR_PAST;
                    m_rel[r_free_idx] <= FAR_PAST;
                end
                if (slot_ok && ((r_hit ? r_wanted[slot_s] : 1'b0) == r_item.key_value)) begin
                    o_word.status <= ST_COALESCED;
                end else if (r_pcount >= CW'(QUEUE_DEPTH)) begin
                    o_word.status <= ST_FULL;
                end else begin
                    o_valid <= 1'b0;
                    if (slot_ok) r_wanted[slot_s] <= r_item.key_value;
                    m_q[r_pcount[QW-1:0]] <= '{mflag: r_item.matrix_modifier,
                        tag: r_item.request_tag, val: r_item.key_value,
                        kc: r_item.key_code};
                    r_pcount <= r_pcount + 1'b1;
                end
            end
            if (i_cmd.do_clear) begin
                r_mods <= '0; r_down <= '0; r_used <= '0; r_wanted <= '0; r_applied <= '0;
                o_valid <= 1'b1;
                o_word <= '{out_key_code: 24'd0, out_value: 1'b0,
                    out_tag: r_item.request_tag, status: ST_CLEAR,
                    modifier_mask: 6'd0, last: 1'b1};
            end
            if (i_cmd.tick_start) begin
                r_frame <= r_frame + 1'b1;
                r_qi <= '0; r_nk <= '0; r_nb <= '0; r_nout <= '0; r_stop <= 1'b0;
                r_walk_active <= 1'b1;
            end
            if (i_cmd.walk_load) begin
                r_e <= q_rd;
                r_bi <= '0; r_is_blk <= 1'b0;
            end
            if (i_cmd.blk_step) begin
                if (r_bi != r_nb) begin
                    r_bi <= r_bi + 1'b1;
                end
            end
            if (i_cmd.clear_step && r_bi != '0 && r_blk_rd == key_id(r_e.kc))
                r_is_blk <= 1'b1;
            if (i_cmd.walk_eval) begin
                r_qi <= r_qi + 1'b1;
                if (r_stop || r_nout >= 6'(MAX_OUT) || r_is_blk) begin
                    if (r_is_blk && i_excl) r_stop <= 1'b1;
                    m_keep[r_nk[QW-1:0]] <= r_e; r_nk <= r_nk + 1'b1;
                end else if (!slot_ok) begin
                    if (r_hv) begin
                        o_valid <= 1'b1;
                        o_word <= r_hw;
                    end
                    r_hv <= 1'b1;
                    r_hw <= '{out_key_code: r_e.kc, out_value: r_e.val, out_tag: r_e.tag,
                        status: ST_NO_SLOT, modifier_mask: r_mods, last: 1'b0};
                    r_nout <= r_nout + 1'b1;
                end else begin
                    if (!r_hit) begin
                        r_used[r_free_idx] <= 1'b1;
                        m_key[r_free_idx] <= r_id;
                        r_wanted[r_free_idx] <= 1'b0;
                        r_applied[r_free_idx] <= 1'b0;
                        m_press[r_free_idx] <= FAR_PAST;
                        m_rel[r_free_idx] <= FAR_PAST;
                    end
                    if (w_gwait || w_xwait) begin
                        if (i_excl) r_stop <= 1'b1;
                        else begin
                            m_blk[r_nb[QW-1:0]] <= key_id(r_e.kc);
                            r_nb <= r_nb + 1'b1;
                        end
                        m_keep[r_nk[QW-1:0]] <= r_e; r_nk <= r_nk + 1'b1;
                    end else begin
                        if (r_hv) begin
                            o_valid <= 1'b1;
                            o_word <= r_hw;
                        end
                        r_hv <= 1'b1;
                        r_hw <= '{out_key_code: r_e.kc, out_value: r_e.val,
                            out_tag: r_e.tag, status: ST_APPLIED,
                            modifier_mask: w_val ? (r_mods | w_b) : (r_mods & ~w_b),
                            last: 1'b0};
                        r_mods <= w_val ? (r_mods | w_b) : (r_mods & ~w_b);
                        r_nout <= r_nout + 1'b1;
                        if (w_val) begin
                            m_press[slot_s] <= r_frame;
                            r_applied[slot_s] <= 1'b1;
                            if (!w_mod && r_down < DOWN_MAX) r_down <= r_down + 1'b1;
                        end else begin
                            m_rel[slot_s] <= r_frame;
                            if ((r_hit && r_applied[slot_s]) && !w_mod) begin
                                if (r_down != 7'd0) r_down <= r_down - 1'b1;
                                r_last_rel <= r_frame;
                            end
                            r_applied[slot_s] <= 1'b0;
                        end
                    end
                end
            end
            if (i_cmd.walk_done) begin
                r_ci <= '0;
                r_pcount <= r_nk;
                r_walk_active <= 1'b0;
                // release the held word as the final result of the tick
                if (r_hv) begin
                    o_valid <= 1'b1;
                    o_word <= '{out_key_code: r_hw.out_key_code, out_value: r_hw.out_value,
                        out_tag: r_hw.out_tag, status: r_hw.status,
                        modifier_mask: r_hw.modifier_mask, last: 1'b1};
                    r_hv <= 1'b0;
                end
            end
            if (i_cmd.copy_step && r_ci != r_nk) begin
                m_q[r_ci[QW-1:0]] <= m_keep[r_ci[QW-1:0]];
                r_ci <= r_ci + 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.find_done  = n_find_done && !r_cmp_v;
        o_sts.walk_more  = r_walk_active && (r_qi < r_pcount);
        o_sts.blk_done   = (r_bi == r_nb);
        o_sts.copy_done  = (r_ci == r_nk);
        o_sts.is_tick    = r_item.func == FUNC_TICK;
        o_sts.is_edge    = r_item.func == FUNC_EDGE;
        o_sts.is_clear   = r_item.func == FUNC_CLEAR;
    end
endmodule
`default_nettype wire

### design/pkes_ctrl.sv
// Controller of the paced key edge scheduler: sequences edge lookup,
// clear and the tick walk. Depends on pkes_pkg.
`default_nettype none
module pkes_ctrl
    import pkes_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_FIND   = 11'b00000000100,
        S_EDGE   = 11'b00000001000,
        S_WLOAD0 = 11'b00000010000,
        S_WLOAD  = 11'b00000100000,
        S_BLK    = 11'b00001000000,
        S_WFIND  = 11'b00010000000,
        S_WEVAL  = 11'b00100000000,
        S_COPY   = 11'b01000000000,
        S_GAP    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_edge) begin
                    o_cmd.find_start = 1'b1;
                    n_state = S_FIND;
                end else if (i_sts.is_tick) begin
                    o_cmd.tick_start = 1'b1;
                    n_state = S_WLOAD0;
                end else if (i_sts.is_clear) begin
                    o_cmd.do_clear = 1'b1;
                    n_state = S_GAP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                o_cmd.find_step = 1'b1;
                if (i_sts.find_done) n_state = S_EDGE;
            end
            S_EDGE: begin
                o_cmd.edge_finish = 1'b1;
                n_state = S_GAP;
            end
            // queue read address settles
            S_WLOAD0: begin
                if (i_sts.walk_more) n_state = S_WLOAD;
                else begin
                    o_cmd.walk_done = 1'b1;
                    n_state = S_COPY;
                end
            end
            S_WLOAD: begin
                o_cmd.walk_load = 1'b1;
                n_state = S_BLK;
            end
            S_BLK: begin
                o_cmd.blk_step = 1'b1;
                o_cmd.clear_step = 1'b1;
                if (i_sts.blk_done) begin
                    n_state = S_WFIND;
                end
            end
            S_WFIND: begin
                o_cmd.find_step = 1'b1;
                if (i_sts.find_done) n_state = S_WEVAL;
            end
            S_WEVAL: begin
                o_cmd.walk_eval = 1'b1;
                n_state = S_WLOAD0;
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.copy_done) n_state = S_GAP;
            end
            S_GAP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // restart slot search when blocked scan ends
        if (r_state == S_BLK && i_sts.blk_done) begin
            o_cmd.find_start = 1'b1;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

### design/paced_key_edge_scheduler_core.sv
// Top level of the paced key edge scheduler: APB register file, controller
// and datapath. Depends on pkes_pkg, pkes_ctrl and pkes_datapath.
//
// Usage: pulse start with an input word while busy is low; the item is
// taken at that edge. Results appear on o_result, one per cycle at most,
// each marked by o_result_valid for one cycle; the receiver cannot stall,
// so every result must be taken when shown. The last result of an item has
// its last bit set.
// Edge items keep busy high through decode, the slot search (one slot compared
// per cycle) and the answer; the answer, if any, shows in the last busy cycle.
// Clear keeps busy through decode and gap, result in gap; unused func: decode only.
// A tick reads each queued edge, runs the blocked-key scan (nb: keys
// blocked so far) and the slot search for it, decides it, then
// compacts the queue. Each tick result shows once the next one is decided;
// the final one shows on the first compaction cycle.
// Registers: hold_frames at 0x0, gap_frames at 0x4, exclusive_mode at 0x8,
// written only while idle (user's rule; not enforced). Reset clears slot use,
// queue, counters and modifier mask; slot contents are written on allocation.
`default_nettype none
module paced_key_edge_scheduler_core
    import pkes_pkg::*;
#(
    parameter int SLOT_COUNT  = 64,
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_in_word   i_item,
    output logic            o_result_valid,
    output t_out_word       o_result,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [3:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    logic [7:0] r_hold, r_gap;
    logic       r_excl;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 8'd3; r_gap <= 8'd3; r_excl <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_HOLD: r_hold <= pwdata[7:0];
                REG_GAP:  r_gap  <= pwdata[7:0];
                REG_EXCL: r_excl <= pwdata[0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_HOLD: prdata = {24'd0, r_hold};
            REG_GAP:  prdata = {24'd0, r_gap};
            REG_EXCL: prdata = {31'd0, r_excl};
            default:  prdata = 32'd0;
        endcase
    end

    pkes_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    pkes_datapath #(.SLOT_COUNT(SLOT_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item),
        .i_hold(r_hold), .i_gap(r_gap), .i_excl(r_excl),
        .i_cmd(cmd), .o_sts(sts), .o_valid(o_result_valid), .o_word(o_result)
    );
endmodule
`default_nettype wire
